FILE: rtl/mfn_pkg.sv
// Shared types and constants for the magnetometer filter / normalizer.
// No dependencies; every other rtl file refers to it by scoped names.
package mfn_pkg;

    localparam int SQRT_STEPS = 32;
    localparam int SQRT_ITERS = (SQRT_STEPS < 32) ? SQRT_STEPS : 32;
    localparam int DIV_BITS   = 15;
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    localparam logic [3:0] CFG_SENSITIVITY = 4'd0;
    localparam logic [3:0] CFG_ALPHA       = 4'd1;
    localparam logic [3:0] CFG_OFFSET_X    = 4'd2;
    localparam logic [3:0] CFG_OFFSET_Y    = 4'd3;
    localparam logic [3:0] CFG_OFFSET_Z    = 4'd4;
    localparam logic [3:0] CFG_GAIN_X      = 4'd5;
    localparam logic [3:0] CFG_GAIN_Y      = 4'd6;
    localparam logic [3:0] CFG_GAIN_Z      = 4'd7;

    localparam logic [15:0] SENSITIVITY_RST = 16'd19661;
    localparam logic [15:0] ALPHA_RST       = 16'd6554;
    localparam logic [15:0] GAIN_RST        = 16'd16384;
    localparam logic [14:0] UNIT_ONE        = 15'd16384;

    typedef struct packed {
        logic             ok;
        logic [2:0][31:0] sc;   // scaled sample per axis, signed Q15.16
    } t_item;

    typedef struct packed {
        logic [15:0]      sensitivity;
        logic [15:0]      iir_weight;
        logic [2:0][23:0] offset;
        logic [2:0][15:0] gain;
    } t_cfg;

    typedef enum logic [3:0] {
        S_IDLE, S_FMUL, S_FADD, S_CMUL, S_CADD, S_SMUL, S_SADD,
        S_ROOT, S_DSET, S_DIV, S_DONE
    } t_state;

endpackage

FILE: rtl/magnetometer_filter_normalize.sv
// A request passes the front register, the queue, 18 filter/correct/square steps,
// 32 root steps, a divide setup, 15 divide steps and the output register; a bus error
// or a sample loaded into an all-zero filter state skips the filter steps.
// The sequencer takes a new request only after its root and divide loops bring it back
// to idle; a zero norm skips the divide steps. Up to three requests queue ahead of it.
// Reset (synchronous, active low) clears the filter state and loads register defaults.
module magnetometer_filter_normalize (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic signed [15:0]  i_sample_x,
    input  logic signed [15:0]  i_sample_y,
    input  logic signed [15:0]  i_sample_z,
    input  logic                i_read_ok,
    output logic                o_valid,
    input  logic                i_ready,
    output logic                o_status,
    output logic signed [15:0]  o_unit_x,
    output logic signed [15:0]  o_unit_y,
    output logic signed [15:0]  o_unit_z,
    output logic signed [31:0]  o_smooth_x,
    output logic signed [31:0]  o_smooth_y,
    output logic signed [31:0]  o_smooth_z,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [3:0]          i_cfg_index,
    input  logic [23:0]         i_cfg_data
);
    mfn_pkg::t_cfg   r_cfg;
    mfn_pkg::t_item  w_f_item;
    mfn_pkg::t_item  w_q_item;
    logic            w_f_push;
    logic            w_f_ready;
    logic            w_q_valid;
    logic            w_q_ready;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sensitivity <= mfn_pkg::SENSITIVITY_RST;
            r_cfg.iir_weight  <= mfn_pkg::ALPHA_RST;
            r_cfg.offset      <= '0;
            for (int a = 0; a < 3; a++) begin
                r_cfg.gain[a] <= mfn_pkg::GAIN_RST;
            end
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                mfn_pkg::CFG_SENSITIVITY: r_cfg.sensitivity <= i_cfg_data[15:0];
                mfn_pkg::CFG_ALPHA:       r_cfg.iir_weight  <= i_cfg_data[15:0];
                mfn_pkg::CFG_OFFSET_X:    r_cfg.offset[0]   <= i_cfg_data;
                mfn_pkg::CFG_OFFSET_Y:    r_cfg.offset[1]   <= i_cfg_data;
                mfn_pkg::CFG_OFFSET_Z:    r_cfg.offset[2]   <= i_cfg_data;
                mfn_pkg::CFG_GAIN_X:      r_cfg.gain[0]     <= i_cfg_data[15:0];
                mfn_pkg::CFG_GAIN_Y:      r_cfg.gain[1]     <= i_cfg_data[15:0];
                mfn_pkg::CFG_GAIN_Z:      r_cfg.gain[2]     <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    mfn_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_sample_x    (i_sample_x),
        .i_sample_y    (i_sample_y),
        .i_sample_z    (i_sample_z),
        .i_read_ok     (i_read_ok),
        .i_sensitivity (r_cfg.sensitivity),
        .o_push        (w_f_push),
        .i_push_ready  (w_f_ready),
        .o_item        (w_f_item)
    );

    mfn_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_push),
        .o_ready (w_f_ready),
        .i_item  (w_f_item),
        .o_valid (w_q_valid),
        .i_ready (w_q_ready),
        .o_item  (w_q_item)
    );

    mfn_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_q_valid  (w_q_valid),
        .o_q_ready  (w_q_ready),
        .i_q_item   (w_q_item),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_status   (o_status),
        .o_unit_x   (o_unit_x),
        .o_unit_y   (o_unit_y),
        .o_unit_z   (o_unit_z),
        .o_smooth_x (o_smooth_x),
        .o_smooth_y (o_smooth_y),
        .o_smooth_z (o_smooth_z)
    );

endmodule

FILE: rtl/mfn_front.sv
// Front end: takes input requests, registers them and scales each axis
// by the sensitivity. Depends on mfn_pkg (t_item).
module mfn_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic signed [15:0]  i_sample_x,
    input  logic signed [15:0]  i_sample_y,
    input  logic signed [15:0]  i_sample_z,
    input  logic                i_read_ok,
    input  logic [15:0]         i_sensitivity,
    output logic                o_push,
    input  logic                i_push_ready,
    output mfn_pkg::t_item      o_item
);
    logic                      r_valid;
    logic                      r_ok;
    logic [2:0][15:0]          r_smp;
    logic signed [32:0]        w_prod [3];

    assign o_ready = !r_valid || i_push_ready;
    assign o_push  = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_ok     <= i_read_ok;
            r_smp[0] <= i_sample_x;
            r_smp[1] <= i_sample_y;
            r_smp[2] <= i_sample_z;
        end
    end

    always_comb begin
        o_item.ok = r_ok;
        for (int a = 0; a < 3; a++) begin
            w_prod[a]    = $signed(r_smp[a]) * $signed({1'b0, i_sensitivity});
            o_item.sc[a] = w_prod[a][31:0];
        end
    end

endmodule

FILE: rtl/mfn_queue.sv
// Short request queue between front end and sequencer.
// Depends on mfn_pkg (t_item, QDEPTH).
module mfn_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  mfn_pkg::t_item i_item,
    output logic           o_valid,
    input  logic           i_ready,
    output mfn_pkg::t_item o_item
);
    mfn_pkg::t_item                 r_mem [mfn_pkg::QDEPTH];
    logic [mfn_pkg::QPTR_W-1:0]     r_wp;
    logic [mfn_pkg::QPTR_W-1:0]     r_rp;
    logic [mfn_pkg::QCNT_W-1:0]     r_count;
    logic                           w_push;
    logic                           w_pop;

    function automatic logic [mfn_pkg::QCNT_W-1:0] QCNT_ONE(input logic b);
        QCNT_ONE = {{(mfn_pkg::QCNT_W-1){1'b0}}, b};
    endfunction

    assign o_ready = r_count != mfn_pkg::QCNT_W'(mfn_pkg::QDEPTH);
    assign o_valid = r_count != '0;
    assign o_item  = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == mfn_pkg::QPTR_W'(mfn_pkg::QDEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= (r_rp == mfn_pkg::QPTR_W'(mfn_pkg::QDEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_count <= r_count + QCNT_ONE(w_push) - QCNT_ONE(w_pop);
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= mfn_pkg::QCNT_W'(mfn_pkg::QDEPTH))
        else $error("queue count beyond depth");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> r_count == $past(r_count) + 1'b1)
        else $error("queue count missed a push");

endmodule

FILE: rtl/mfn_back.sv
// Sequencer: IIR filter, iron correction, root of the squared norm and
// three-lane division into a unit vector. Depends on mfn_pkg.
module mfn_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mfn_pkg::t_cfg       i_cfg,
    input  logic                i_q_valid,
    output logic                o_q_ready,
    input  mfn_pkg::t_item      i_q_item,
    output logic                o_valid,
    input  logic                i_ready,
    output logic                o_status,
    output logic signed [15:0]  o_unit_x,
    output logic signed [15:0]  o_unit_y,
    output logic signed [15:0]  o_unit_z,
    output logic signed [31:0]  o_smooth_x,
    output logic signed [31:0]  o_smooth_y,
    output logic signed [31:0]  o_smooth_z
);
    mfn_pkg::t_state     r_state, n_state;
    logic [1:0]          r_ax;
    logic [5:0]          r_cnt;
    logic                r_ok;
    logic [2:0][31:0]    r_sc;
    logic signed [31:0]  r_st [3];
    logic signed [31:0]  r_c  [3];
    logic [31:0]         r_mag [3];
    logic signed [49:0]  r_fprod;
    logic signed [48:0]  r_cprod;
    logic [63:0]         r_sq;
    logic [63:0]         r_sum;
    logic [63:0]         r_rad;
    logic [33:0]         r_rem;
    logic [31:0]         r_root;
    logic [31:0]         r_norm;
    logic [46:0]         r_den;
    logic [46:0]         r_drem [3];
    logic [mfn_pkg::DIV_BITS-1:0] r_q [3];
    logic                r_out_valid;

    logic                w_zero_st;
    logic                w_out_free;
    logic                w_ax_last;
    logic signed [32:0]  w_fdiff;
    logic signed [50:0]  w_fsum;
    logic signed [35:0]  w_fnew;
    logic signed [35:0]  w_cdiff;
    logic signed [31:0]  w_cd;
    logic signed [49:0]  w_csum;
    logic signed [31:0]  w_cval;
    logic [32:0]         w_cneg;
    logic [35:0]         w_cand;
    logic [35:0]         w_trial;
    logic [31:0]         w_root_nx;

    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        if (!v[35] && (|v[34:31])) begin
            sat32 = 32'sh7FFF_FFFF;
        end else if (v[35] && !(&v[34:31])) begin
            sat32 = 32'sh8000_0000;
        end else begin
            sat32 = v[31:0];
        end
    endfunction

    function automatic logic [15:0] unit_of(input logic [mfn_pkg::DIV_BITS-1:0] q,
                                            input logic neg);
        logic [15:0] qc;
        qc = (q > mfn_pkg::UNIT_ONE) ? {1'b0, mfn_pkg::UNIT_ONE} : {1'b0, q};
        unit_of = neg ? 16'(-qc) : qc;
    endfunction

    assign w_zero_st  = (r_st[0] == 0) && (r_st[1] == 0) && (r_st[2] == 0);
    assign w_out_free = !r_out_valid || i_ready;
    assign w_ax_last  = r_ax == 2'd2;

    always_comb begin
        w_fdiff   = $signed({r_sc[r_ax][31], r_sc[r_ax]})
                    - $signed({r_st[r_ax][31], r_st[r_ax]});
        w_fsum    = $signed({r_fprod[49], r_fprod}) + 51'sd32768;
        w_fnew    = $signed({{4{r_st[r_ax][31]}}, r_st[r_ax]})
                    + $signed({w_fsum[50], w_fsum[50:16]});
        w_cdiff   = $signed({{4{r_st[r_ax][31]}}, r_st[r_ax]})
                    - $signed({{4{i_cfg.offset[r_ax][23]}}, i_cfg.offset[r_ax], 8'b0});
        w_cd      = sat32(w_cdiff);
        w_csum    = $signed({r_cprod[48], r_cprod}) + 50'sd8192;
        w_cval    = sat32($signed(w_csum[49:14]));
        w_cneg    = 33'd0 - {w_cval[31], w_cval};
        w_cand    = {r_rem, r_rad[63:62]};
        w_trial   = {2'b00, r_root, 2'b01};
        w_root_nx = {r_root[30:0], (w_cand >= w_trial)};
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mfn_pkg::S_IDLE: begin
                if (i_q_valid) begin
                    n_state = (i_q_item.ok && !w_zero_st) ? mfn_pkg::S_FMUL
                                                          : mfn_pkg::S_CMUL;
                end
            end
            mfn_pkg::S_FMUL: n_state = mfn_pkg::S_FADD;
            mfn_pkg::S_FADD: n_state = w_ax_last ? mfn_pkg::S_CMUL : mfn_pkg::S_FMUL;
            mfn_pkg::S_CMUL: n_state = mfn_pkg::S_CADD;
            mfn_pkg::S_CADD: n_state = w_ax_last ? mfn_pkg::S_SMUL : mfn_pkg::S_CMUL;
            mfn_pkg::S_SMUL: n_state = mfn_pkg::S_SADD;
            mfn_pkg::S_SADD: n_state = w_ax_last ? mfn_pkg::S_ROOT : mfn_pkg::S_SMUL;
            mfn_pkg::S_ROOT: begin
                if (r_cnt == 6'(mfn_pkg::SQRT_ITERS - 1)) begin
                    n_state = mfn_pkg::S_DSET;
                end
            end
            mfn_pkg::S_DSET: n_state = (r_norm == 0) ? mfn_pkg::S_DONE : mfn_pkg::S_DIV;
            mfn_pkg::S_DIV: begin
                if (r_cnt == 6'(mfn_pkg::DIV_BITS - 1)) begin
                    n_state = mfn_pkg::S_DONE;
                end
            end
            mfn_pkg::S_DONE: begin
                if (w_out_free) begin
                    n_state = mfn_pkg::S_IDLE;
                end
            end
            default: n_state = mfn_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_q_ready = r_state == mfn_pkg::S_IDLE;
        o_valid   = r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mfn_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_st[0]     <= '0;
            r_st[1]     <= '0;
            r_st[2]     <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == mfn_pkg::S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == mfn_pkg::S_IDLE && i_q_valid && i_q_item.ok && w_zero_st) begin
                for (int a = 0; a < 3; a++) begin
                    r_st[a] <= $signed(i_q_item.sc[a]);
                end
            end else if (r_state == mfn_pkg::S_FADD) begin
                r_st[r_ax] <= sat32(w_fnew);
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            mfn_pkg::S_IDLE: begin
                r_ok  <= i_q_item.ok;
                r_sc  <= i_q_item.sc;
                r_ax  <= '0;
                r_sum <= '0;
            end
            mfn_pkg::S_FMUL: begin
                r_fprod <= w_fdiff * $signed({1'b0, i_cfg.iir_weight});
            end
            mfn_pkg::S_FADD: begin
                r_ax <= w_ax_last ? 2'd0 : r_ax + 2'd1;
            end
            mfn_pkg::S_CMUL: begin
                r_cprod <= w_cd * $signed({1'b0, i_cfg.gain[r_ax]});
            end
            mfn_pkg::S_CADD: begin
                r_c[r_ax]   <= w_cval;
                r_mag[r_ax] <= w_cval[31] ? w_cneg[31:0] : w_cval;
                r_ax        <= w_ax_last ? 2'd0 : r_ax + 2'd1;
            end
            mfn_pkg::S_SMUL: begin
                r_sq <= r_mag[r_ax] * r_mag[r_ax];
            end
            mfn_pkg::S_SADD: begin
                r_sum  <= r_sum + r_sq;
                r_rad  <= r_sum + r_sq;
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= '0;
                r_ax   <= w_ax_last ? 2'd0 : r_ax + 2'd1;
            end
            mfn_pkg::S_ROOT: begin
                // two radicand bits per step, one root bit out
                r_rem  <= (w_cand >= w_trial) ? 34'(w_cand - w_trial) : w_cand[33:0];
                r_root <= w_root_nx;
                r_rad  <= {r_rad[61:0], 2'b00};
                r_cnt  <= r_cnt + 6'd1;
                if (r_cnt == 6'(mfn_pkg::SQRT_ITERS - 1)) begin
                    r_norm <= w_root_nx << (32 - mfn_pkg::SQRT_ITERS);
                end
            end
            mfn_pkg::S_DSET: begin
                r_den <= {1'b0, r_norm, 14'b0};
                r_cnt <= '0;
                for (int a = 0; a < 3; a++) begin
                    r_drem[a] <= {1'b0, r_mag[a], 14'b0} + {16'b0, r_norm[31:1]};
                    r_q[a]    <= '0;
                end
            end
            mfn_pkg::S_DIV: begin
                for (int a = 0; a < 3; a++) begin
                    if (r_drem[a] >= r_den) begin
                        r_drem[a] <= r_drem[a] - r_den;
                        r_q[a]    <= {r_q[a][mfn_pkg::DIV_BITS-2:0], 1'b1};
                    end else begin
                        r_q[a]    <= {r_q[a][mfn_pkg::DIV_BITS-2:0], 1'b0};
                    end
                end
                r_den <= {1'b0, r_den[46:1]};
                r_cnt <= r_cnt + 6'd1;
            end
            mfn_pkg::S_DONE: begin
                if (w_out_free) begin
                    o_status   <= !r_ok;
                    o_smooth_x <= r_st[0];
                    o_smooth_y <= r_st[1];
                    o_smooth_z <= r_st[2];
                    if (r_norm == 0) begin
                        o_unit_x <= '0;
                        o_unit_y <= '0;
                        o_unit_z <= '0;
                    end else begin
                        // X comes out negated
                        o_unit_x <= unit_of(r_q[0], !r_c[0][31]);
                        o_unit_y <= unit_of(r_q[1], r_c[1][31]);
                        o_unit_z <= unit_of(r_q[2], r_c[2][31]);
                    end
                end
            end
            default: begin
                r_ax <= '0;
            end
        endcase
    end

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_q_valid && o_q_ready) |=> r_state != mfn_pkg::S_IDLE)
        else $error("popped request not taken up");

    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_unit_y <= 16'sd16384 && o_unit_y >= -16'sd16384
                     && o_unit_z <= 16'sd16384 && o_unit_z >= -16'sd16384))
        else $error("unit component out of range");

    a_div_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == mfn_pkg::S_DIV |-> r_norm != 0)
        else $error("division entered with zero norm");

endmodule

FILE: bench/tb.sv
// Testbench for magnetometer_filter_normalize: directed table plus random samples,
// checked against an in-bench fixed-point filter/normalizer. Depends on rtl/mfn_pkg.sv.
`timescale 1ns / 1ps

module tb;

    typedef struct packed {
        logic             status;
        logic [2:0][15:0] unit;
        logic [2:0][31:0] smooth;
    } t_heading;

    typedef struct {
        logic [15:0] x, y, z;
        logic        ok;
        logic        has_exp;
        t_heading    exp;
    } t_row;

    logic        i_clk, i_rst_n;
    logic        i_valid, o_ready, i_read_ok;
    logic signed [15:0] i_sample_x, i_sample_y, i_sample_z;
    logic        o_valid, i_ready, o_status;
    logic signed [15:0] o_unit_x, o_unit_y, o_unit_z;
    logic signed [31:0] o_smooth_x, o_smooth_y, o_smooth_z;
    logic        i_cfg_valid, o_cfg_ready;
    logic [3:0]  i_cfg_index;
    logic [23:0] i_cfg_data;

    magnetometer_filter_normalize u_dut (.*);

    // predictor state
    logic [15:0]        m_sens, m_alpha;
    logic [2:0][23:0]   m_off;
    logic [2:0][15:0]   m_gain;
    logic signed [31:0] m_filt [3];

    t_heading heading_q[$];
    int       n_err, n_checked, n_bus_err;
    int       send_idle, recv_idle;

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #50_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // floor of (v + 2^(n-1)) / 2^n; >>> on longint is arithmetic
    function automatic longint rnd_shr(longint v, int n);
        return (v + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function automatic void model_reset();
        m_sens = mfn_pkg::SENSITIVITY_RST;
        m_alpha = mfn_pkg::ALPHA_RST;
        m_off = '0;
        m_gain = {3{mfn_pkg::GAIN_RST}};
        for (int a = 0; a < 3; a++) m_filt[a] = 0;
    endfunction

    function automatic void model_write(logic [3:0] idx, logic [23:0] d);
        case (idx)
            mfn_pkg::CFG_SENSITIVITY: m_sens = d[15:0];
            mfn_pkg::CFG_ALPHA:       m_alpha = d[15:0];
            mfn_pkg::CFG_OFFSET_X:    m_off[0] = d;
            mfn_pkg::CFG_OFFSET_Y:    m_off[1] = d;
            mfn_pkg::CFG_OFFSET_Z:    m_off[2] = d;
            mfn_pkg::CFG_GAIN_X:      m_gain[0] = d[15:0];
            mfn_pkg::CFG_GAIN_Y:      m_gain[1] = d[15:0];
            mfn_pkg::CFG_GAIN_Z:      m_gain[2] = d[15:0];
            default: ;
        endcase
    endfunction

    function automatic t_heading predict_heading(logic [15:0] sx, logic [15:0] sy,
                                                 logic [15:0] sz, logic ok);
        t_heading h;
        longint sc[3], c[3], st, d;
        logic [63:0] sum, r, t, mag, q, norm;
        logic [15:0] s[3];
        s[0] = sx; s[1] = sy; s[2] = sz;
        if (ok) begin
            for (int a = 0; a < 3; a++)
                sc[a] = longint'($signed(s[a])) * longint'({1'b0, m_sens});
            if (m_filt[0] == 0 && m_filt[1] == 0 && m_filt[2] == 0) begin
                for (int a = 0; a < 3; a++) m_filt[a] = 32'(sat32(sc[a]));
            end else begin
                for (int a = 0; a < 3; a++) begin
                    st = m_filt[a];
                    d = rnd_shr(longint'({1'b0, m_alpha}) * (sc[a] - st), 16);
                    m_filt[a] = 32'(sat32(st + d));
                end
            end
        end
        sum = 0;
        for (int a = 0; a < 3; a++) begin
            d = sat32(longint'(m_filt[a]) - longint'($signed(m_off[a])) * 256);
            c[a] = sat32(rnd_shr(d * longint'({1'b0, m_gain[a]}), 14));
            mag = (c[a] < 0) ? -c[a] : c[a];
            sum += mag * mag;
        end
        r = 0;
        for (int i = 0; i < mfn_pkg::SQRT_ITERS; i++) begin
            t = r | (64'd1 << (31 - i));
            if (t * t <= sum) r = t;
        end
        norm = r;
        h.status = !ok;
        for (int a = 0; a < 3; a++) begin
            if (norm == 0) q = 0;
            else begin
                mag = (c[a] < 0) ? -c[a] : c[a];
                q = (mag * 16384 + norm / 2) / norm;
                if (q > 16384) q = 16384;
            end
            if ((c[a] < 0) != (a == 0)) q = -q;
            if (norm == 0) q = 0;
            h.unit[a] = q[15:0];
            h.smooth[a] = m_filt[a];
        end
        return h;
    endfunction

    // result side: random stall, compare against oldest expectation
    always @(posedge i_clk) begin
        t_heading got, want;
        if (!i_rst_n) i_ready <= 1'b0;
        else begin
            if (o_valid && i_ready) begin
                got.status = o_status;
                got.unit = {o_unit_z, o_unit_y, o_unit_x};
                got.smooth = {o_smooth_z, o_smooth_y, o_smooth_x};
                n_checked++;
                if (heading_q.size() == 0) begin
                    n_err++;
                    if (n_err <= 10) $display("unexpected result %h", got);
                end else begin
                    want = heading_q.pop_front();
                    if (got !== want) begin
                        n_err++;
                        if (n_err <= 10)
                            $display("mismatch: exp st=%0d u=%h s=%h got st=%0d u=%h s=%h",
                                     want.status, want.unit, want.smooth,
                                     got.status, got.unit, got.smooth);
                    end
                end
            end
            i_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // valid stays high after acceptance until the next idle cycle or drain drops it
    task automatic send_sample(logic [15:0] x, logic [15:0] y, logic [15:0] z,
                               logic ok, logic has_exp, t_heading e);
        t_heading p;
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_sample_x <= x; i_sample_y <= y; i_sample_z <= z; i_read_ok <= ok;
        do @(posedge i_clk); while (!o_ready);
        p = predict_heading(x, y, z, ok);
        if (ok) n_bus_err += 0; else n_bus_err++;
        if (has_exp && p !== e) begin
            n_err++;
            if (n_err <= 10) $display("table row disagrees: exp %h pred %h", e, p);
        end
        heading_q.push_back(has_exp ? e : p);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        i_valid <= 1'b0;
        while (heading_q.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [3:0] idx, logic [23:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        model_write(idx, d);
    endtask

    function automatic logic [15:0] rnd_axis();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($urandom_range(31)) - 16'd16;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_config(int mode);
        logic [23:0] v;
        for (int i = 0; i < 8; i++) begin
            if (mode == 0) v = (i < 2) ? 24'hffff : ((i < 5) ? 24'h800000 : 24'hffff);
            else if (mode == 1) v = (i < 2) ? 24'h0001 : ((i < 5) ? 24'h7fffff : 24'h0);
            else if (i < 2) v = 24'($urandom);
            else if (i < 5) v = ($urandom_range(3) == 0) ? 24'($urandom)
                                : 24'($signed(12'($urandom)));
            else v = 24'($urandom_range(32768, 8192));
            write_reg(4'(i), v);
        end
        write_reg(4'd9, 24'($urandom)); // unused index, ignored
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(int n);
        t_heading none;
        none = '0;
        for (int k = 0; k < n; k++)
            send_sample(rnd_axis(), rnd_axis(), rnd_axis(),
                        $urandom_range(7) != 0, 1'b0, none);
    endtask

    t_row rows[$];

    function automatic t_row mk(logic [15:0] x, logic [15:0] y, logic [15:0] z, logic ok,
                                logic he, t_heading e);
        t_row r;
        r.x = x; r.y = y; r.z = z; r.ok = ok; r.has_exp = he; r.exp = e;
        return r;
    endfunction

    initial begin
        t_heading zero, none;
        n_err = 0; n_checked = 0; n_bus_err = 0;
        send_idle = 21; recv_idle = 58;
        i_rst_n = 0; i_valid = 0; i_sample_x = 0; i_sample_y = 0; i_sample_z = 0;
        i_read_ok = 0; i_cfg_valid = 0; i_cfg_index = 0; i_cfg_data = 0;
        model_reset();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        zero = '0; zero.status = 1'b1; none = '0;
        // bus error right after reset: zero state, zero norm
        rows.push_back(mk(16'h1234, 16'h5678, 16'h9abc, 1'b0, 1'b1, zero));
        // zero sample into zero state keeps it zero
        rows.push_back(mk(16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1, '0));
        rows.push_back(mk(16'h7fff, 16'h8000, 16'h0001, 1'b1, 1'b0, none));
        rows.push_back(mk(16'h8000, 16'h7fff, 16'hffff, 1'b1, 1'b0, none));
        rows.push_back(mk(16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0, none));
        rows.push_back(mk(16'hffff, 16'hffff, 16'hffff, 1'b1, 1'b0, none));
        rows.push_back(mk(16'h0100, 16'h0000, 16'h0000, 1'b1, 1'b0, none));
        rows.push_back(mk(16'h0000, 16'h0100, 16'h0000, 1'b1, 1'b0, none));
        rows.push_back(mk(16'h0000, 16'h0000, 16'h8000, 1'b1, 1'b0, none));
        rows.push_back(mk(16'h5555, 16'haaaa, 16'h5555, 1'b0, 1'b0, none));
        rows.push_back(mk(16'haaaa, 16'h5555, 16'haaaa, 1'b1, 1'b0, none));
        foreach (rows[i])
            send_sample(rows[i].x, rows[i].y, rows[i].z, rows[i].ok,
                        rows[i].has_exp, rows[i].exp);
        random_phase(150);
        drain();

        random_config(0);
        random_phase(120);
        drain();
        random_config(1);
        random_phase(120);
        drain();

        send_idle = 58; recv_idle = 21;
        random_config(2);
        random_phase(250);
        drain();
        send_idle = 0; recv_idle = 0;
        random_config(2);
        random_phase(250);
        drain();
        random_config(2);
        random_phase(250);
        drain();

        $display("checked %0d results (%0d bus errors) over six register settings",
                 n_checked, n_bus_err);
        if (n_err == 0 && heading_q.size() == 0) $display("SUCCESS");
        else begin
            $display("%0d mismatches, %0d left waiting", n_err, heading_q.size());
            $display("FAILURE");
        end
        $finish;
    end
endmodule
